// ----- rtl/vrefr_pkg.sv -----
// vrefr_pkg: widths and types for vector_refraction
// no dependencies
package vrefr_pkg;

  localparam int unsigned CompW   = 16;
  localparam int unsigned SqW     = 34;   // sum of three squares
  localparam int unsigned QW      = 33;   // sqrt(S * 2^32)
  localparam int unsigned QuotW   = 48;   // dividend width for u
  localparam int unsigned DiscW   = 56;   // covers normals off unit length
  localparam int unsigned SW      = 28;   // sqrt(disc)

  typedef logic signed [CompW-1:0] comp_t;

  typedef struct packed {
    comp_t inc_x;
    comp_t inc_y;
    comp_t inc_z;
    comp_t nrm_x;
    comp_t nrm_y;
    comp_t nrm_z;
    logic [CompW-1:0] index_ratio;
  } in_word_t;

  typedef struct packed {
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    logic refracts;
  } out_word_t;

endpackage

// ----- rtl/vrefr_if.sv -----
// vrefr_if: valid/ready channel carrying one payload word
// depends on nothing; payload type is a parameter
interface vrefr_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/vector_refraction.sv -----
// vector_refraction: vector snell refraction, fully pipelined
// depends on vrefr_pkg, vrefr_if, vrefr_sqrt, vrefr_div
//
//  channel  dir  word        fields
//  in_ch    in   in_word_t   inc_x/y/z, nrm_x/y/z, index_ratio
//  out_ch   out  out_word_t  out_x/y/z, refracts
//
// one word per cycle while out_ch is not stalled; stages in order: a, b, first
// root, dividers, e to i, second root, j, l, m, output; one bit per root/div stage.
// the whole pipe advances when the output register is free or taken (one
// global enable), so a stall freezes every stage and nothing is lost.
// reset clears valid bits.
module vector_refraction (
  input logic clk_i,
  input logic rst_ni,
  vrefr_if.sink   in_ch,
  vrefr_if.source out_ch
);
  localparam int unsigned SideW = 7 * 16 + 1;
  localparam int unsigned DW    = vrefr_pkg::DiscW;
  localparam int unsigned SW    = vrefr_pkg::SW;

  logic en;
  logic out_vld_q;
  vrefr_pkg::out_word_t out_q;

  assign en          = !out_vld_q || out_ch.ready;
  assign in_ch.ready = en;

  // stage a: squares
  logic        a_vld_q;
  vrefr_pkg::in_word_t a_w_q;
  logic [31:0] a_sx_q, a_sy_q, a_sz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= in_ch.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_w_q  <= in_ch.data;
      a_sx_q <= 32'(in_ch.data.inc_x * in_ch.data.inc_x);
      a_sy_q <= 32'(in_ch.data.inc_y * in_ch.data.inc_y);
      a_sz_q <= 32'(in_ch.data.inc_z * in_ch.data.inc_z);
    end
  end

  // stage b: sum
  logic        b_vld_q;
  vrefr_pkg::in_word_t b_w_q;
  logic [vrefr_pkg::SqW-1:0] b_s_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (en) b_vld_q <= a_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_w_q <= a_w_q;
      b_s_q <= 34'(a_sx_q) + 34'(a_sy_q) + 34'(a_sz_q);
    end
  end

  // q = isqrt(S << 32), zero flag rides in the sideband
  logic        q_vld;
  logic [vrefr_pkg::QW-1:0] q_root;
  logic [SideW-1:0] q_side;
  vrefr_sqrt #(.InW(66), .SideW(SideW)) u_sqrt_q (
    .clk_i, .rst_ni, .en_i(en), .valid_i(b_vld_q),
    .rad_i({b_s_q, 32'b0}), .side_i({b_w_q, b_s_q == 34'd0}),
    .valid_o(q_vld), .root_o(q_root), .side_o(q_side)
  );

  // three dividers for |inc| * 2^30 + q/2 over q
  vrefr_pkg::in_word_t c_w;
  logic c_zero;
  assign c_w    = q_side[SideW-1:1];
  assign c_zero = q_side[0];
  logic [vrefr_pkg::QuotW-1:0] num [3];
  logic [15:0] cinc [3];
  assign cinc[0] = c_w.inc_x;
  assign cinc[1] = c_w.inc_y;
  assign cinc[2] = c_w.inc_z;
  for (genvar i = 0; i < 3; i++) begin : g_num
    logic [15:0] mag;
    assign mag    = cinc[i][15] ? 16'(-cinc[i]) : cinc[i];
    assign num[i] = {2'b0, mag, 30'b0} + 48'(q_root >> 1);
  end
  logic        dv_vld [3];
  logic [vrefr_pkg::QuotW-1:0] quo [3];
  logic [SideW-1:0] dv_side [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    vrefr_div #(.NW(vrefr_pkg::QuotW), .DW(vrefr_pkg::QW), .SideW(SideW)) u_div (
      .clk_i, .rst_ni, .en_i(en), .valid_i(q_vld),
      .num_i(num[i]), .den_i(q_root), .side_i(q_side),
      .valid_o(dv_vld[i]), .quo_o(quo[i]), .side_o(dv_side[i])
    );
  end

  vrefr_pkg::in_word_t e_w;
  logic e_zero;
  assign e_w    = dv_side[0][SideW-1:1];
  assign e_zero = dv_side[0][0];
  logic signed [16:0] u [3];
  logic signed [15:0] en_n [3];
  assign en_n[0] = e_w.nrm_x;
  assign en_n[1] = e_w.nrm_y;
  assign en_n[2] = e_w.nrm_z;
  logic [15:0] einc [3];
  assign einc[0] = e_w.inc_x;
  assign einc[1] = e_w.inc_y;
  assign einc[2] = e_w.inc_z;
  for (genvar i = 0; i < 3; i++) begin : g_u
    assign u[i] = einc[i][15] ? -$signed(17'(quo[i])) : $signed(17'(quo[i]));
  end

  // stage e: products u*n
  logic e_vld_q, e_zero_q;
  vrefr_pkg::in_word_t e_w_q;
  logic signed [16:0] u_q [3];
  logic signed [32:0] un_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_vld_q <= 1'b0;
    else if (en) e_vld_q <= dv_vld[0];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_w_q <= e_w;
      e_zero_q <= e_zero;
      for (int i = 0; i < 3; i++) begin
        u_q[i]  <= u[i];
        un_q[i] <= 33'(u[i] * en_n[i]);
      end
    end
  end

  // stage f: d
  logic f_vld_q, f_zero_q;
  vrefr_pkg::in_word_t f_w_q;
  logic signed [16:0] f_u_q [3];
  logic signed [34:0] d_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_vld_q <= 1'b0;
    else if (en) f_vld_q <= e_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_w_q <= e_w_q;
      f_zero_q <= e_zero_q;
      f_u_q <= u_q;
      d_q <= 35'(un_q[0]) + 35'(un_q[1]) + 35'(un_q[2]);
    end
  end

  // stage g: d*d and r*r
  logic f_dneg;
  logic [33:0] f_dm;
  assign f_dneg = d_q[34];
  assign f_dm   = 34'(f_dneg ? -d_q : d_q);
  logic g_vld_q, g_zero_q;
  vrefr_pkg::in_word_t g_w_q;
  logic signed [16:0] g_u_q [3];
  logic signed [34:0] g_d_q;
  logic [67:0] g_dd_q;
  logic [31:0] g_rr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_vld_q <= 1'b0;
    else if (en) g_vld_q <= f_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      g_w_q <= f_w_q;
      g_zero_q <= f_zero_q;
      g_u_q <= f_u_q;
      g_d_q <= d_q;
      g_dd_q <= 68'(f_dm) * 68'(f_dm);
      g_rr_q <= 32'(f_w_q.index_ratio) * 32'(f_w_q.index_ratio);
    end
  end

  // stage h: om and r2
  logic [39:0] g_ddr;
  assign g_ddr = 40'((g_dd_q + 68'(1 << 27)) >> 28);
  logic h_vld_q, h_zero_q;
  vrefr_pkg::in_word_t h_w_q;
  logic signed [16:0] h_u_q [3];
  logic signed [34:0] h_d_q;
  logic signed [33:0] h_om_q;
  logic [24:0] h_r2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h_vld_q <= 1'b0;
    else if (en) h_vld_q <= g_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      h_w_q <= g_w_q;
      h_zero_q <= g_zero_q;
      h_u_q <= g_u_q;
      h_d_q <= g_d_q;
      h_om_q <= 34'($signed(41'(1) << 28) - $signed({1'b0, g_ddr}));
      h_r2_q <= 25'((33'(g_rr_q) + 33'd128) >> 8);
    end
  end

  // stage i: disc
  logic signed [66:0] h_prod;
  assign h_prod = 67'($signed({1'b0, h_r2_q}) * h_om_q);
  logic i_vld_q, i_ok_q;
  vrefr_pkg::in_word_t i_w_q;
  logic signed [16:0] i_u_q [3];
  logic signed [34:0] i_d_q;
  logic [DW-1:0] i_disc_q;
  logic signed [66:0] h_disc;
  assign h_disc = $signed(67'(1) << 44) - h_prod;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) i_vld_q <= 1'b0;
    else if (en) i_vld_q <= h_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      i_w_q <= h_w_q;
      i_u_q <= h_u_q;
      i_d_q <= h_d_q;
      i_ok_q <= !h_zero_q && (h_disc > 0);
      i_disc_q <= (h_disc > 0) ? DW'(h_disc) : '0;
    end
  end

  // s = isqrt(disc)
  localparam int unsigned JSideW = $bits(vrefr_pkg::in_word_t) + 1 + 16 + 3 * 17 + 35;
  logic s_vld;
  logic [SW-1:0] s_root;
  logic [JSideW-1:0] s_side;
  vrefr_sqrt #(.InW(DW), .SideW(JSideW)) u_sqrt_s (
    .clk_i, .rst_ni, .en_i(en), .valid_i(i_vld_q),
    .rad_i(i_disc_q),
    .side_i({i_w_q, i_ok_q, i_w_q.index_ratio, i_u_q[0], i_u_q[1], i_u_q[2], i_d_q}),
    .valid_o(s_vld), .root_o(s_root), .side_o(s_side)
  );

  vrefr_pkg::in_word_t j_w;
  logic j_ok;
  logic [15:0] j_r;
  logic signed [16:0] j_u [3];
  logic signed [34:0] j_d;
  assign {j_w, j_ok, j_r, j_u[0], j_u[1], j_u[2], j_d} = s_side;
  logic signed [15:0] j_n [3];
  assign j_n[0] = j_w.nrm_x;
  assign j_n[1] = j_w.nrm_y;
  assign j_n[2] = j_w.nrm_z;

  // stage j: n*d, n*s
  logic k_vld_q, k_ok_q;
  logic [15:0] k_r_q;
  logic signed [16:0] k_u_q [3];
  logic signed [50:0] k_nd_q [3];
  logic signed [44:0] k_ns_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) k_vld_q <= 1'b0;
    else if (en) k_vld_q <= s_vld;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      k_ok_q <= j_ok;
      k_r_q <= j_r;
      k_u_q <= j_u;
      for (int i = 0; i < 3; i++) begin
        k_nd_q[i] <= 51'(j_n[i] * j_d);
        k_ns_q[i] <= 45'(j_n[i] * $signed({1'b0, s_root}));
      end
    end
  end

  // stage l: t rounded
  logic l_vld_q, l_ok_q;
  logic [15:0] l_r_q;
  logic signed [39:0] l_t_q [3];
  logic signed [44:0] l_ns_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) l_vld_q <= 1'b0;
    else if (en) l_vld_q <= k_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      l_ok_q <= k_ok_q;
      l_r_q <= k_r_q;
      l_ns_q <= k_ns_q;
      for (int i = 0; i < 3; i++) begin
        logic signed [52:0] v;
        logic [52:0] m;
        v = ($signed(53'(k_u_q[i])) <<< 28) - 53'(k_nd_q[i]);
        m = v[52] ? 53'(-v) : 53'(v);
        m = (m + 53'(1 << 13)) >> 14;
        l_t_q[i] <= v[52] ? -$signed(40'(m)) : $signed(40'(m));
      end
    end
  end

  // stage m: r*t - 16*n*s
  logic m_vld_q, m_ok_q;
  logic signed [58:0] m_acc_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_vld_q <= 1'b0;
    else if (en) m_vld_q <= l_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_ok_q <= l_ok_q;
      for (int i = 0; i < 3; i++) begin
        m_acc_q[i] <= 59'($signed({1'b0, l_r_q}) * l_t_q[i])
                      - ($signed(59'(l_ns_q[i])) <<< 4);
      end
    end
  end

  // output: round, saturate
  vrefr_pkg::comp_t res [3];
  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [58:0] mg;
    logic [32:0] rq;
    assign mg = m_acc_q[i][58] ? 59'(-m_acc_q[i]) : 59'(m_acc_q[i]);
    assign rq = 33'((mg + 59'(1 << 25)) >> 26);
    always_comb begin
      if (!m_ok_q) res[i] = '0;
      else if (m_acc_q[i][58]) res[i] = (rq > 33'd32768) ? 16'sh8000 : 16'(-rq);
      else res[i] = (rq > 33'd32767) ? 16'sh7fff : 16'(rq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= m_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.out_x <= res[0];
      out_q.out_y <= res[1];
      out_q.out_z <= res[2];
      out_q.refracts <= m_ok_q;
    end
  end

  assign out_ch.valid = out_vld_q;
  assign out_ch.data  = out_q;

  a_no_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.refracts |-> out_q.out_x == 0 && out_q.out_y == 0 && out_q.out_z == 0)
    else $error("zero vector expected without refraction");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ch.ready |=> out_vld_q && $stable(out_q))
    else $error("stalled output changed");
  a_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready == (!out_vld_q || out_ch.ready))
    else $error("pipe enable mismatch");
endmodule

// ----- rtl/vrefr_sqrt.sv -----
// vrefr_sqrt: pipelined integer square root, one result bit per stage
// depends on nothing; width generic, carries a sideband word along
module vrefr_sqrt #(
  parameter int unsigned InW = 66,
  parameter int unsigned SideW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [InW-1:0]       rad_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 valid_o,
  output logic [(InW+1)/2-1:0] root_o,
  output logic [SideW-1:0]     side_o
);
  localparam int unsigned RW = (InW + 1) / 2;
  localparam int unsigned PW = 2 * RW;

  logic [PW-1:0]    rem_q [RW+1];
  logic [RW-1:0]    root_q [RW+1];
  logic [SideW-1:0] side_q [RW+1];
  logic [RW:0]      vld_q;

  assign rem_q[0]  = PW'(rad_i);
  assign root_q[0] = '0;
  assign side_q[0] = side_i;
  assign vld_q[0]  = valid_i;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int unsigned B = RW - 1 - k;
    logic [PW-1:0] trial;
    logic          fits;
    // trial = (root << (B+1)) + (1 << 2B)
    assign trial = (PW'(root_q[k]) << (B + 1)) | (PW'(1) << (2 * B));
    assign fits  = rem_q[k] >= trial;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= fits ? rem_q[k] - trial : rem_q[k];
        root_q[k+1] <= root_q[k] | (fits ? (RW'(1) << B) : '0);
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[RW];
  assign root_o  = root_q[RW];
  assign side_o  = side_q[RW];
endmodule

// ----- rtl/vrefr_div.sv -----
// vrefr_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing; carries a sideband word along
module vrefr_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 33,
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NW-1:0]    num_i,
  input  logic [DW-1:0]    den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NW-1:0]    quo_o,
  output logic [SideW-1:0] side_o
);
  logic [DW:0]      rem_q [NW+1];
  logic [NW-1:0]    num_q [NW+1];
  logic [DW-1:0]    den_q [NW+1];
  logic [SideW-1:0] side_q [NW+1];
  logic [NW:0]      vld_q;

  assign rem_q[0]  = '0;
  assign num_q[0]  = num_i;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;
  assign vld_q[0]  = valid_i;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW+1:0] sh;
    logic          fits;
    assign sh   = {rem_q[k], num_q[k][NW-1]};
    assign fits = sh >= {2'b0, den_q[k]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= fits ? (DW+1)'(sh - {2'b0, den_q[k]}) : (DW+1)'(sh);
        // numerator shifts out at the top, quotient bits fill the bottom
        num_q[k+1]  <= {num_q[k][NW-2:0], fits};
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[NW];
  assign quo_o   = num_q[NW];
  assign side_o  = side_q[NW];
endmodule
